// ----- rtl/rgb_pixel_blend_unit_assert.svh -----
// ---------------------------------------------------------------------------
// rgb_pixel_blend_unit_assert.svh
// Assertion macros used by the pixel blend top module. Build with NO_ASSERTIONS
// defined to compile them out.
// ---------------------------------------------------------------------------
`ifndef RGB_PIXEL_BLEND_UNIT_ASSERT_SVH
`define RGB_PIXEL_BLEND_UNIT_ASSERT_SVH

`ifndef NO_ASSERTIONS

// cond must hold at every clock edge outside reset
`define RPB_ASSERT_ALWAYS(lbl, cond) \
  lbl: assert property (@(posedge clk) disable iff (rst) (cond)) \
    else $error("pixel blend check failed");

// when ante holds, cons must hold at the next clock edge
`define RPB_ASSERT_NEXT(lbl, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
    else $error("pixel blend check failed");

`else

`define RPB_ASSERT_ALWAYS(lbl, cond)
`define RPB_ASSERT_NEXT(lbl, ante, cons)

`endif

`endif

// ----- rtl/rpb_pkg.sv -----
// ---------------------------------------------------------------------------
// rpb_pkg
// Types and constants for the RGB pixel blend unit.
// ---------------------------------------------------------------------------
package rpb_pkg;

  localparam int unsigned CHAN_W = 8;
  localparam int unsigned IDX_W  = 2;

  localparam logic [CHAN_W-1:0] CHAN_MAX = 8'd255;

  // configuration register indexes
  localparam logic [IDX_W-1:0] REG_BLEND_MODE   = 2'd0;
  localparam logic [IDX_W-1:0] REG_GREEN_OFFSET = 2'd1;
  localparam logic [IDX_W-1:0] REG_RED_SCALE    = 2'd2;

  // codes 6 and 7 pass the top pixel through
  typedef enum logic [2:0] {
    MODE_MULTIPLY  = 3'd0,
    MODE_SUBTRACT  = 3'd1,
    MODE_SCREEN    = 3'd2,
    MODE_OVERLAY   = 3'd3,
    MODE_ADD_GREEN = 3'd4,
    MODE_SCALE_RED = 3'd5
  } blend_mode_t;

  typedef struct packed {
    blend_mode_t       mode;
    logic [CHAN_W-1:0] green_offset;
    logic [CHAN_W-1:0] red_scale;
  } cfg_t;

endpackage

// ----- rtl/rpb_lane.sv -----
// ---------------------------------------------------------------------------
// rpb_lane
// One color channel of the two-image blend: multiply, subtract, screen,
// overlay. Stage 1 registers the 8x8 product; stage 2 rounds by 255.
// ---------------------------------------------------------------------------
module rpb_lane
  import rpb_pkg::*;
(
  input  logic              clk,
  input  logic              en,
  input  blend_mode_t       mode,
  input  logic [CHAN_W-1:0] t,
  input  logic [CHAN_W-1:0] b,
  output logic [CHAN_W-1:0] res
);

  logic [CHAN_W-1:0]   x;
  logic [CHAN_W-1:0]   y;
  logic                dbl_next;
  logic                inv_next;

  logic [2*CHAN_W-1:0] prod;
  logic                dbl;
  logic                inv;
  logic                use_sub;
  logic [CHAN_W-1:0]   sub_val;

  // operand select; screen and upper overlay work on the complements
  always_comb begin
    x        = t;
    y        = b;
    dbl_next = 1'b0;
    inv_next = 1'b0;
    case (mode)
      MODE_SCREEN: begin
        x        = ~t;
        y        = ~b;
        inv_next = 1'b1;
      end
      MODE_OVERLAY: begin
        dbl_next = 1'b1;
        if (b[CHAN_W-1]) begin
          x        = ~t;
          y        = ~b;
          inv_next = 1'b1;
        end
      end
      default: begin
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (en) begin
      prod    <= x * y;
      dbl     <= dbl_next;
      inv     <= inv_next;
      use_sub <= (mode == MODE_SUBTRACT);
      sub_val <= (t > b) ? '0 : (b - t);
    end
  end

  // floor((k*prod + 255) / 510) == floor(m / 255), m = (k*prod + 255) >> 1
  logic [17:0] n;
  logic [16:0] m;
  logic [16:0] msum;
  logic [8:0]  e;
  logic [16:0] e255;
  logic [16:0] r;
  logic [8:0]  d;

  always_comb begin
    n    = (dbl ? {prod, 2'b00} : {1'b0, prod, 1'b0}) + 18'd255;
    m    = n[17:1];
    msum = m + {8'd0, m[16:8]};
    e    = msum[16:8];             // short by at most one
    e255 = {e, 8'd0} - {8'd0, e};
    r    = m - e255;
    if (r >= 17'd510) begin
      d = e + 9'd2;
    end else if (r >= 17'd255) begin
      d = e + 9'd1;
    end else begin
      d = e;
    end
    if (use_sub) begin
      res = sub_val;
    end else if (inv) begin
      res = CHAN_MAX - d[CHAN_W-1:0];
    end else begin
      res = d[CHAN_W-1:0];
    end
  end

endmodule

// ----- rtl/rpb_merge.sv -----
// ---------------------------------------------------------------------------
// rpb_merge
// Combines the lane results with the single-image modes (add green,
// scale red, pass-through) into the final pixel.
// ---------------------------------------------------------------------------
module rpb_merge
  import rpb_pkg::*;
(
  input  logic              clk,
  input  logic              en,
  input  cfg_t              cfg,
  input  logic [CHAN_W-1:0] top_r,
  input  logic [CHAN_W-1:0] top_g,
  input  logic [CHAN_W-1:0] top_b,
  input  logic [CHAN_W-1:0] lane_r,
  input  logic [CHAN_W-1:0] lane_g,
  input  logic [CHAN_W-1:0] lane_b,
  output logic [CHAN_W-1:0] res_r,
  output logic [CHAN_W-1:0] res_g,
  output logic [CHAN_W-1:0] res_b
);

  logic [CHAN_W:0]     gsum;
  logic [2*CHAN_W-1:0] rprod;
  logic [CHAN_W-1:0]   ovr_r_next;
  logic [CHAN_W-1:0]   ovr_g_next;
  logic [CHAN_W-1:0]   ovr_b_next;

  logic                ovr;
  logic [CHAN_W-1:0]   ovr_r;
  logic [CHAN_W-1:0]   ovr_g;
  logic [CHAN_W-1:0]   ovr_b;

  always_comb begin
    gsum       = {1'b0, top_g} + {1'b0, cfg.green_offset};
    rprod      = top_r * cfg.red_scale;
    ovr_r_next = top_r;
    ovr_g_next = top_g;
    ovr_b_next = top_b;
    case (cfg.mode)
      MODE_ADD_GREEN: begin
        ovr_g_next = gsum[CHAN_W] ? CHAN_MAX : gsum[CHAN_W-1:0];
      end
      MODE_SCALE_RED: begin
        ovr_r_next = (|rprod[2*CHAN_W-1:CHAN_W]) ? CHAN_MAX : rprod[CHAN_W-1:0];
        ovr_b_next = '0;
      end
      default: begin
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (en) begin
      ovr   <= (cfg.mode != MODE_MULTIPLY) && (cfg.mode != MODE_SUBTRACT) &&
               (cfg.mode != MODE_SCREEN) && (cfg.mode != MODE_OVERLAY);
      ovr_r <= ovr_r_next;
      ovr_g <= ovr_g_next;
      ovr_b <= ovr_b_next;
    end
  end

  assign res_r = ovr ? ovr_r : lane_r;
  assign res_g = ovr ? ovr_g : lane_g;
  assign res_b = ovr ? ovr_b : lane_b;

endmodule

// ----- rtl/rgb_pixel_blend_unit.sv -----
// ---------------------------------------------------------------------------
// rgb_pixel_blend_unit
// Blends a top and a bottom RGB pixel per beat in one of six modes:
// multiply, subtract, screen, overlay, add green, scale red.
// ---------------------------------------------------------------------------
//
//   channel  dir  handshake              payload
//   -------  ---  ---------------------  ---------------------------------
//   in       in   in_valid / in_stall    top_red/green/blue, bottom_*
//   out      out  out_valid / out_stall  out_red, out_green, out_blue
//   cfg      in   cfg_write              cfg_index, cfg_data
//
// One beat per clock sustained while out_stall is low. An accepted beat
// reaches out_valid through stage 1, which holds the per-lane 8x8 products,
// and stage 2, which rounds by 255 in each lane while the merge picks the
// final channel values into the output register.
// in_stall rises only when both stages hold a beat and out_stall is high.
// Synchronous reset empties the pipe and loads the register defaults
// (multiply, green offset 0, red scale 1).
//
`include "rgb_pixel_blend_unit_assert.svh"

module rgb_pixel_blend_unit
  import rpb_pkg::*;
(
  input  logic              clk,
  input  logic              rst,

  input  logic              cfg_write,
  input  logic [IDX_W-1:0]  cfg_index,
  input  logic [CHAN_W-1:0] cfg_data,

  input  logic              in_valid,
  output logic              in_stall,
  input  logic [CHAN_W-1:0] top_red,
  input  logic [CHAN_W-1:0] top_green,
  input  logic [CHAN_W-1:0] top_blue,
  input  logic [CHAN_W-1:0] bottom_red,
  input  logic [CHAN_W-1:0] bottom_green,
  input  logic [CHAN_W-1:0] bottom_blue,

  output logic              out_valid,
  input  logic              out_stall,
  output logic [CHAN_W-1:0] out_red,
  output logic [CHAN_W-1:0] out_green,
  output logic [CHAN_W-1:0] out_blue
);

  // ---- configuration registers ----
  cfg_t cfg;

  always_ff @(posedge clk) begin
    if (rst) begin
      cfg.mode         <= MODE_MULTIPLY;
      cfg.green_offset <= '0;
      cfg.red_scale    <= 8'd1;
    end else if (cfg_write) begin
      case (cfg_index)
        REG_BLEND_MODE:   cfg.mode         <= blend_mode_t'(cfg_data[2:0]);
        REG_GREEN_OFFSET: cfg.green_offset <= cfg_data;
        REG_RED_SCALE:    cfg.red_scale    <= cfg_data;
        default: begin
          // index past the register list: ignored
        end
      endcase
    end
  end

  // ---- pipeline control ----
  // out register frees when empty or taken; stage 1 frees when it can
  // move into the out register. Bubbles collapse.
  logic s1_valid;
  logic out_ready;
  logic s1_ready;
  logic in_acc;
  logic s1_move;

  assign out_ready = !out_valid || !out_stall;
  assign s1_ready  = !s1_valid || out_ready;
  assign in_stall  = !s1_ready;
  assign in_acc    = in_valid && s1_ready;
  assign s1_move   = s1_valid && out_ready;

  always_ff @(posedge clk) begin
    if (rst) begin
      s1_valid  <= 1'b0;
      out_valid <= 1'b0;
    end else begin
      if (in_acc) begin
        s1_valid <= 1'b1;
      end else if (s1_move) begin
        s1_valid <= 1'b0;
      end
      if (s1_move) begin
        out_valid <= 1'b1;
      end else if (!out_stall) begin
        out_valid <= 1'b0;
      end
    end
  end

  // ---- lanes: one per color channel ----
  logic [CHAN_W-1:0] lane_r;
  logic [CHAN_W-1:0] lane_g;
  logic [CHAN_W-1:0] lane_b;

  rpb_lane u_lane_r (
    .clk  (clk),
    .en   (in_acc),
    .mode (cfg.mode),
    .t    (top_red),
    .b    (bottom_red),
    .res  (lane_r)
  );

  rpb_lane u_lane_g (
    .clk  (clk),
    .en   (in_acc),
    .mode (cfg.mode),
    .t    (top_green),
    .b    (bottom_green),
    .res  (lane_g)
  );

  rpb_lane u_lane_b (
    .clk  (clk),
    .en   (in_acc),
    .mode (cfg.mode),
    .t    (top_blue),
    .b    (bottom_blue),
    .res  (lane_b)
  );

  // ---- merge: single-image modes override the lane results ----
  logic [CHAN_W-1:0] mrg_r;
  logic [CHAN_W-1:0] mrg_g;
  logic [CHAN_W-1:0] mrg_b;

  rpb_merge u_merge (
    .clk    (clk),
    .en     (in_acc),
    .cfg    (cfg),
    .top_r  (top_red),
    .top_g  (top_green),
    .top_b  (top_blue),
    .lane_r (lane_r),
    .lane_g (lane_g),
    .lane_b (lane_b),
    .res_r  (mrg_r),
    .res_g  (mrg_g),
    .res_b  (mrg_b)
  );

  // ---- output register ----
  always_ff @(posedge clk) begin
    if (s1_move) begin
      out_red   <= mrg_r;
      out_green <= mrg_g;
      out_blue  <= mrg_b;
    end
  end

  // ---- checks ----
  // input backs up only with the whole pipe full and the sink stalled
  `RPB_ASSERT_ALWAYS(a_stall_only_full, !in_stall || (s1_valid && out_valid && out_stall))
  // an accepted beat always lands in stage 1
  `RPB_ASSERT_NEXT(a_accept_fills_s1, in_acc, s1_valid)
  // a stage 1 beat blocked by the output stays put
  `RPB_ASSERT_NEXT(a_s1_holds, s1_valid && !out_ready, s1_valid)
  // a stage 1 beat that moves always shows up at the output
  `RPB_ASSERT_NEXT(a_move_fills_out, s1_move, out_valid)

endmodule
